// File: hw/rtl/tsmg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the twin sieve max gap core.
package tsmg_pkg;

  localparam int BoundW = 6;
  localparam int CntW   = 25;
  localparam int PosW   = 24;

  typedef struct packed {
    logic          too_large;
    logic [CntW-1:0] modulus;
    logic [CntW-1:0] predicted_count;
    logic [CntW-1:0] survivor_count;
    logic          count_match;
    logic [CntW-1:0] max_gap;
    logic [PosW-1:0] gap_start;
    logic [CntW-1:0] max_gap_count;
    logic [PosW-1:0] least_max_start;
  } tsmg_result_t;

endpackage

// File: hw/rtl/twin_sieve_max_gap_core.sv
`timescale 1ns / 1ps
// Top level: twin-prime admissible residue sieve and maximal cyclic gap search.
//
// Assert start with in_prime_bound while busy is low; busy then stays high until the
// single result appears on the out_ ports for one cycle, marked by out_valid. The
// receiver cannot stall, so the result must be taken in that cycle. Run time is set
// by the one bitmap RAM port, which reads or writes one 64-bit word per cycle. After
// trial division and products, the bitmap is cleared word by word, each struck residue
// (0 and p-2 modulo every prime) takes a read-modify-write, and two full walks test one
// bit per cycle with a word read before each word. The largest primorial that fits is
// 9699690; too_large items skip the clear, the strikes and the walks.
module twin_sieve_max_gap_core
  import tsmg_pkg::*;
#(
  parameter int SIEVE_BITS = 16777216,
  parameter int MAX_PRIMES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [BoundW-1:0] in_prime_bound,
  output logic              out_valid,
  output logic              out_too_large,
  output logic [CntW-1:0]   out_modulus,
  output logic [CntW-1:0]   out_predicted_count,
  output logic [CntW-1:0]   out_survivor_count,
  output logic              out_count_match,
  output logic [CntW-1:0]   out_max_gap,
  output logic [PosW-1:0]   out_gap_start,
  output logic [CntW-1:0]   out_max_gap_count,
  output logic [PosW-1:0]   out_least_max_start
);

  localparam int Words = (SIEVE_BITS + 63) / 64;
  localparam int AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int PW    = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int PTW   = $clog2(MAX_PRIMES + 1);
  localparam int RW    = 40;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_TRY   = 13'b0000000000010,
    S_DIV   = 13'b0000000000100,
    S_PROD  = 13'b0000000001000,
    S_CLR   = 13'b0000000010000,
    S_SINIT = 13'b0000000100000,
    S_SRD   = 13'b0000001000000,
    S_SWR   = 13'b0000010000000,
    S_WRD   = 13'b0000100000000,
    S_WBIT  = 13'b0001000000000,
    S_WRAP  = 13'b0010000000000,
    S_DONE  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state_r;

  logic [BoundW-1:0] bound_r;
  logic [BoundW-1:0] n_r, d_r;
  logic [BoundW-1:0] rem_r;
  logic [BoundW-1:0] plist_r [MAX_PRIMES];
  logic [PTW-1:0]    ptot_r, pi_r;
  logic              over_r;
  logic [RW-1:0]     m_r, pred_r;
  logic [RW-1:0]     r_r;
  logic              pass_r;
  logic [CntW-1:0]   surv_r, best_r, cnt_r, pos_r;
  logic [CntW-1:0]   prev_r, first_r, last_r, bestat_r, least_r, wrap_r;
  logic              pvalid_r, fvalid_r, hleast_r, second_r;
  logic [5:0]        bit_r;
  logic [63:0]       word_r;
  tsmg_result_t      res_r;
  logic              ovalid_r;

  logic              we;
  logic [AW-1:0]     addr;
  logic [63:0]       wdata, rdata;

  tsmg_ram #(.Width(64), .Depth(Words)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [BoundW-1:0] p_cur;
  logic [RW-1:0]     prod;
  logic [CntW-1:0]   gap;
  logic              surv_bit;

  assign p_cur    = plist_r[pi_r[PW-1:0]];
  assign prod     = m_r * {{(RW-BoundW){1'b0}}, p_cur};
  assign gap      = pos_r - prev_r;
  assign surv_bit = (bit_r == 6'd0) ? ~rdata[0] : ~word_r[bit_r];

  always_comb begin
    we    = 1'b0;
    addr  = r_r[AW+5:6];
    wdata = rdata | (64'd1 << r_r[5:0]);
    if (state_r == S_CLR) begin
      we    = 1'b1;
      wdata = '0;
    end
    if (state_r == S_SWR) begin
      we = 1'b1;
    end
    if (state_r == S_WRD || state_r == S_WBIT) begin
      addr = pos_r[AW+5:6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ptot_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE: if (start) begin
          bound_r <= in_prime_bound;
          n_r     <= 6'd2;
          ptot_r  <= '0;
          over_r  <= 1'b0;
          state_r <= S_TRY;
        end
        S_TRY: begin
          d_r   <= 6'd2;
          rem_r <= n_r;
          pi_r  <= '0;
          m_r   <= 40'd1;
          pred_r <= 40'd1;
          state_r <= (n_r > bound_r || n_r == 6'd0) ? S_PROD : S_DIV;
        end
        S_DIV: begin
          // repeated subtraction for n mod d
          if ({6'd0, d_r} * {6'd0, d_r} > {6'd0, n_r}) begin
            if (ptot_r >= PTW'(MAX_PRIMES)) begin
              over_r  <= 1'b1;
              state_r <= S_PROD;
            end else begin
              plist_r[ptot_r[PW-1:0]] <= n_r;
              ptot_r  <= ptot_r + 1'b1;
              n_r     <= n_r + 1'b1;
              state_r <= S_TRY;
            end
          end else if (rem_r >= d_r) begin
            rem_r <= rem_r - d_r;
          end else if (rem_r == '0) begin
            n_r     <= n_r + 1'b1;
            state_r <= S_TRY;
          end else begin
            d_r   <= d_r + 1'b1;
            rem_r <= n_r;
          end
        end
        S_PROD: begin
          if (over_r) begin
            state_r <= S_DONE;
          end else if (pi_r == ptot_r) begin
            r_r     <= '0;
            state_r <= S_CLR;
          end else begin
            m_r <= prod;
            if (prod > RW'(SIEVE_BITS)) begin
              over_r <= 1'b1;
            end
            if (p_cur >= 6'd3) begin
              pred_r <= pred_r * {{(RW-BoundW){1'b0}}, p_cur - 6'd2};
            end
            pi_r <= pi_r + 1'b1;
          end
        end
        S_CLR: begin
          if (r_r + 40'd64 >= m_r) begin
            pi_r    <= '0;
            pass_r  <= 1'b0;
            state_r <= S_SINIT;
          end
          r_r <= r_r + 40'd64;
        end
        S_SINIT: begin
          if (pi_r == ptot_r) begin
            pos_r    <= '0;
            surv_r   <= '0;
            best_r   <= '0;
            bestat_r <= '0;
            pvalid_r <= 1'b0;
            fvalid_r <= 1'b0;
            second_r <= 1'b0;
            cnt_r    <= '0;
            hleast_r <= 1'b0;
            least_r  <= '0;
            last_r   <= '0;
            state_r  <= S_WRD;
          end else begin
            r_r     <= pass_r ? RW'(p_cur - 6'd2) : '0;
            state_r <= S_SRD;
          end
        end
        S_SRD: state_r <= S_SWR;
        S_SWR: begin
          if (r_r + RW'(p_cur) >= m_r) begin
            pass_r <= ~pass_r;
            if (pass_r) pi_r <= pi_r + 1'b1;
            state_r <= S_SINIT;
          end else begin
            state_r <= S_SRD;
          end
          r_r <= r_r + RW'(p_cur);
        end
        S_WBIT: begin
          if (bit_r == 6'd0) word_r <= rdata;
          if (surv_bit) begin
            if (!second_r) begin
              surv_r <= surv_r + 1'b1;
              if (!fvalid_r) begin
                first_r  <= pos_r;
                fvalid_r <= 1'b1;
              end
              if (pvalid_r && gap > best_r) begin
                best_r   <= gap;
                bestat_r <= prev_r;
              end
              last_r <= pos_r;
            end else if (pvalid_r && gap == best_r) begin
              cnt_r <= cnt_r + 1'b1;
              if (!hleast_r || prev_r < least_r) begin
                least_r  <= prev_r;
                hleast_r <= 1'b1;
              end
            end
            prev_r   <= pos_r;
            pvalid_r <= 1'b1;
          end
          pos_r <= pos_r + 1'b1;
          bit_r <= bit_r + 1'b1;
          if (RW'(pos_r) + 40'd1 >= m_r) begin
            state_r <= S_WRAP;
          end else if (bit_r == 6'd63) begin
            state_r <= S_WRD;
          end
        end
        S_WRD: begin
          bit_r   <= '0;
          state_r <= S_WBIT;
        end
        S_WRAP: begin
          if (!second_r) begin
            if (surv_r == '0) begin
              state_r <= S_DONE;
            end else begin
              wrap_r <= first_r + CntW'(m_r) - last_r;
              if (first_r + CntW'(m_r) - last_r > best_r) begin
                best_r   <= first_r + CntW'(m_r) - last_r;
                bestat_r <= last_r;
              end
              second_r <= 1'b1;
              pvalid_r <= 1'b0;
              pos_r    <= '0;
              state_r  <= S_WRD;
            end
          end else begin
            if (wrap_r == best_r) begin
              cnt_r <= cnt_r + 1'b1;
              if (!hleast_r || last_r < least_r) begin
                least_r <= last_r;
              end
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (over_r) begin
            res_r <= '{too_large: 1'b1, default: '0};
          end else begin
            res_r.too_large       <= 1'b0;
            res_r.modulus         <= CntW'(m_r);
            res_r.predicted_count <= CntW'(pred_r);
            res_r.survivor_count  <= surv_r;
            res_r.count_match     <= (CntW'(pred_r) == surv_r);
            res_r.max_gap         <= best_r;
            res_r.gap_start       <= bestat_r[PosW-1:0];
            res_r.max_gap_count   <= cnt_r;
            res_r.least_max_start <= least_r[PosW-1:0];
          end
          state_r <= S_OUT;
        end
        S_OUT:   state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = ovalid_r;
  assign out_too_large       = res_r.too_large;
  assign out_modulus         = res_r.modulus;
  assign out_predicted_count = res_r.predicted_count;
  assign out_survivor_count  = res_r.survivor_count;
  assign out_count_match     = res_r.count_match;
  assign out_max_gap         = res_r.max_gap;
  assign out_gap_start       = res_r.gap_start;
  assign out_max_gap_count   = res_r.max_gap_count;
  assign out_least_max_start = res_r.least_max_start;

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe outside a busy window");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("block still busy after result");
  a_ptot: assert property (@(posedge clk) disable iff (!rst_n)
    ptot_r <= PTW'(MAX_PRIMES)) else $error("prime count overflow");

endmodule

// File: hw/rtl/tsmg_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module tsmg_ram #(
  parameter int Width = 64,
  parameter int Depth = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: tb/tb_twin_sieve_max_gap_core.sv
`timescale 1ns / 1ps
// Testbench for twin_sieve_max_gap_core: queued bounds, in-bench gap predictor, result check.
module tb_twin_sieve_max_gap_core;
  import tsmg_pkg::*;

  localparam longint SieveBits = 16777216;
  localparam int     MaxPrimes = 16;
  localparam longint CycleLimit = 60000000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [BoundW-1:0] in_prime_bound;
  logic              out_valid;
  logic              out_too_large;
  logic [CntW-1:0]   out_modulus;
  logic [CntW-1:0]   out_predicted_count;
  logic [CntW-1:0]   out_survivor_count;
  logic              out_count_match;
  logic [CntW-1:0]   out_max_gap;
  logic [PosW-1:0]   out_gap_start;
  logic [CntW-1:0]   out_max_gap_count;
  logic [PosW-1:0]   out_least_max_start;

  twin_sieve_max_gap_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_prime_bound      (in_prime_bound),
    .out_valid           (out_valid),
    .out_too_large       (out_too_large),
    .out_modulus         (out_modulus),
    .out_predicted_count (out_predicted_count),
    .out_survivor_count  (out_survivor_count),
    .out_count_match     (out_count_match),
    .out_max_gap         (out_max_gap),
    .out_gap_start       (out_gap_start),
    .out_max_gap_count   (out_max_gap_count),
    .out_least_max_start (out_least_max_start)
  );

  int unsigned  bound_q[$];
  tsmg_result_t gap_expect_q[$];
  int           mismatches = 0;
  int           sent;
  int           drain_at;
  int           idle_left;
  longint       cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic tsmg_result_t twin_gap_of(int unsigned x);
    tsmg_result_t r;
    longint       primes[$];
    longint       m, pred, surv, best, best_at, wrap, cnt, least;
    longint       first, last, prev, n, d, p;
    bit           have_prev, have_first, have_least, over, is_prime;
    bit           struck[];
    r = '0;
    m = 1;
    pred = 1;
    over = 0;
    for (n = 2; n <= x; n++) begin
      is_prime = 1;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) begin
          is_prime = 0;
          break;
        end
      end
      if (!is_prime) continue;
      if (primes.size() >= MaxPrimes) begin
        over = 1;
        break;
      end
      primes.push_back(n);
    end
    if (!over) begin
      foreach (primes[i]) begin
        m *= primes[i];
        if (m > SieveBits) begin
          over = 1;
          break;
        end
        if (primes[i] >= 3) pred *= primes[i] - 2;
      end
    end
    if (over) begin
      r.too_large = 1'b1;
      return r;
    end
    struck = new[m];
    foreach (primes[i]) begin
      p = primes[i];
      for (n = 0; n < m; n += p) struck[n] = 1'b1;
      for (n = (p - 2) % p; n < m; n += p) struck[n] = 1'b1;
    end
    surv = 0; best = 0; best_at = 0; cnt = 0; least = 0;
    first = 0; last = 0; prev = 0; wrap = 0;
    have_prev = 0; have_first = 0; have_least = 0;
    for (n = 0; n < m; n++) begin
      if (struck[n]) continue;
      surv++;
      if (!have_first) begin
        first = n;
        have_first = 1;
      end
      if (have_prev && n - prev > best) begin
        best = n - prev;
        best_at = prev;
      end
      prev = n;
      have_prev = 1;
      last = n;
    end
    if (surv != 0) begin
      wrap = first + m - last;
      if (wrap > best) begin
        best = wrap;
        best_at = last;
      end
      have_prev = 0;
      for (n = 0; n < m; n++) begin
        if (struck[n]) continue;
        if (have_prev && n - prev == best) begin
          cnt++;
          if (!have_least || prev < least) begin
            least = prev;
            have_least = 1;
          end
        end
        prev = n;
        have_prev = 1;
      end
      if (wrap == best) begin
        cnt++;
        if (!have_least || last < least) begin
          least = last;
          have_least = 1;
        end
      end
    end
    r.modulus         = m[CntW-1:0];
    r.predicted_count = pred[CntW-1:0];
    r.survivor_count  = surv[CntW-1:0];
    r.count_match     = (surv == pred);
    r.max_gap         = best[CntW-1:0];
    r.gap_start       = best_at[PosW-1:0];
    r.max_gap_count   = cnt[CntW-1:0];
    r.least_max_start = least[PosW-1:0];
    return r;
  endfunction

  function automatic int unsigned idle_draw();
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_prime_bound <= '0;
      idle_left <= 0;
      sent <= 0;
    end else if (start && !busy) begin
      gap_expect_q.push_back(twin_gap_of(32'(in_prime_bound)));
      sent <= sent + 1;
      start <= 1'b0;
      idle_left <= idle_draw();
    end else if (!start) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
      end else if (bound_q.size() != 0 && !(sent == drain_at && gap_expect_q.size() != 0)) begin
        in_prime_bound <= BoundW'(bound_q.pop_front());
        start <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h", name, expv, actv);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    tsmg_result_t e;
    if (rst_n && out_valid) begin
      if (gap_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: result transfer with nothing expected");
      end else begin
        e = gap_expect_q.pop_front();
        check_field("too_large", e.too_large, out_too_large);
        check_field("modulus", e.modulus, out_modulus);
        check_field("predicted_count", e.predicted_count, out_predicted_count);
        check_field("survivor_count", e.survivor_count, out_survivor_count);
        check_field("count_match", e.count_match, out_count_match);
        check_field("max_gap", e.max_gap, out_max_gap);
        check_field("gap_start", e.gap_start, out_gap_start);
        check_field("max_gap_count", e.max_gap_count, out_max_gap_count);
        check_field("least_max_start", e.least_max_start, out_least_max_start);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
    end
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    rst_n = 1'b0;
    drain_at = 30;
    bound_q = '{0, 1, 2, 3, 4, 5, 6, 7, 11, 13, 17, 23, 63, 58, 59, 53, 31, 47, 8,
                9, 10, 12};
    for (int i = 0; i < 78; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) bound_q.push_back($urandom_range(0, 12));
      else if (sel == 6) bound_q.push_back($urandom_range(13, 16));
      else bound_q.push_back($urandom_range(23, 63));
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (bound_q.size() != 0 || start || gap_expect_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tsmg_pkg.sv
hw/rtl/tsmg_ram.sv
hw/rtl/twin_sieve_max_gap_core.sv
tb/tb_twin_sieve_max_gap_core.sv
